// ===== src/pse_pkg.sv =====
package pse_pkg;

  localparam int unsigned CORDIC_STAGES_DEF = 20;
  localparam int unsigned SAMPLE_BITS_DEF   = 24;
  localparam int unsigned GUARD_BITS        = 4;

  // field and register widths
  localparam int unsigned OMEGA_W  = 20;
  localparam int unsigned INVV_W   = 24;
  localparam int unsigned DZ_W     = 16;
  localparam int unsigned DIP_W    = 17;
  localparam int unsigned KX_W     = 24;
  localparam int unsigned STEPS_W  = 16;

  // internal widths
  localparam int unsigned KRAW_W   = OMEGA_W + INVV_W;
  localparam int unsigned K_W      = KRAW_W - 16;
  localparam int unsigned K2_W     = 2 * K_W;
  localparam int unsigned KX2_W    = 2 * KX_W - 1;
  localparam int unsigned RHS_W    = K2_W + DIP_W;
  localparam int unsigned KZ_W     = K_W;
  localparam int unsigned SD_W     = STEPS_W + DZ_W;
  localparam int unsigned PHI_W    = 60;
  localparam int unsigned THETA_W  = 35;
  localparam int unsigned Z_W      = 37;
  localparam int unsigned GAIN_W   = 27;

  localparam int unsigned CFG_ADDR_W = 4;

  // angles in 2^-32 rad
  localparam logic [PHI_W-1:0]        TWO_PI_PHI = 60'd26986075409;
  localparam logic signed [Z_W-1:0]   Z_TWO_PI   = 37'sd26986075409;
  localparam logic signed [Z_W-1:0]   Z_PI       = 37'sd13493037705;
  localparam logic signed [Z_W-1:0]   Z_HALF_PI  = 37'sd6746518852;
  localparam logic [63:0]             QUARTER_PI = 64'd3373259426;

  typedef enum logic [1:0] {
    REG_INV_VEL    = 2'd0,
    REG_DEPTH_STEP = 2'd1,
    REG_DIP_COS    = 2'd2
  } pse_reg_e;

  // elaboration-time helpers, restoring long division and square root
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [63:0] isqrt64f(input logic [63:0] val);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = val;
    r = '0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] atan_fx(input int idx);
    logic [63:0] sum;
    logic [63:0] term;
    int          e;
    sum = '0;
    if (idx == 0) begin
      return QUARTER_PI;
    end
    for (int n = 0; n < 64; n++) begin
      e = 62 - idx * (2 * n + 1);
      if (e >= 0) begin
        term = udiv64(64'd1 << e, 64'(2 * n + 1));
        if ((n % 2) == 1) sum = sum - term;
        else sum = sum + term;
      end
    end
    return (sum + (64'd1 << 29)) >> 30;
  endfunction

  function automatic logic [63:0] inv_gain_fx(input int stages);
    logic [63:0] p;
    p = 64'd1 << 60;
    for (int i = 0; i < stages; i++) begin
      p = p + (p >> (2 * i));
    end
    return udiv64(64'd1 << 56, isqrt64f(p));
  endfunction

endpackage

// ===== src/pse_sample_if.sv =====
interface pse_sample_if #(
  parameter int unsigned SampleBits = pse_pkg::SAMPLE_BITS_DEF
);
  import pse_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] sample_re;
  logic signed [SampleBits-1:0] sample_im;
  logic [OMEGA_W-1:0]           angular_freq;
  logic signed [KX_W-1:0]       wavenumber;
  logic [STEPS_W-1:0]           depth_steps;

  modport source (
    output valid, sample_re, sample_im, angular_freq, wavenumber, depth_steps,
    input  ready
  );
  modport sink (
    input  valid, sample_re, sample_im, angular_freq, wavenumber, depth_steps,
    output ready
  );
endinterface

// ===== src/pse_result_if.sv =====
interface pse_result_if #(
  parameter int unsigned SampleBits = pse_pkg::SAMPLE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] result_re;
  logic signed [SampleBits-1:0] result_im;
  logic                         was_cut;

  modport source (
    output valid, result_re, result_im, was_cut,
    input  ready
  );
  modport sink (
    input  valid, result_re, result_im, was_cut,
    output ready
  );
endinterface

// ===== src/pse_isqrt.sv =====
module pse_isqrt #(
  parameter int unsigned SideW = 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [pse_pkg::K2_W-1:0]  rad_i,
  input  logic [SideW-1:0]          side_i,
  output logic                      valid_o,
  output logic [pse_pkg::KZ_W-1:0]  root_o,
  output logic [SideW-1:0]          side_o
);
  import pse_pkg::*;

  localparam int unsigned RW     = K2_W + 1;
  localparam int unsigned ITERS  = K2_W / 2;
  localparam int unsigned PER    = 2;
  localparam int unsigned STAGES = ITERS / PER;

  logic [STAGES-1:0] v_q;
  logic [RW-1:0]     rem_q  [STAGES];
  logic [RW-1:0]     root_q [STAGES];
  logic [RW-1:0]     rem_d  [STAGES];
  logic [RW-1:0]     root_d [STAGES];
  logic [SideW-1:0]  side_q [STAGES];

  // two result bits per stage, MSB first
  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [RW-1:0] rem_in;
    logic [RW-1:0] root_in;
    logic [RW-1:0] rem_nx;
    logic [RW-1:0] root_nx;
    logic [RW-1:0] bit_v;

    if (s == 0) begin : g_first
      assign rem_in  = RW'(rad_i);
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
    end

    always_comb begin
      rem_nx  = rem_in;
      root_nx = root_in;
      bit_v   = '0;
      for (int k = 0; k < PER; k++) begin
        bit_v = RW'(1) << (K2_W - 2 - 2 * (s * PER + k));
        if (rem_nx >= root_nx + bit_v) begin
          rem_nx  = rem_nx - (root_nx + bit_v);
          root_nx = (root_nx >> 1) + bit_v;
        end else begin
          root_nx = root_nx >> 1;
        end
      end
    end

    assign rem_d[s]  = rem_nx;
    assign root_d[s] = root_nx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[STAGES-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int s = 0; s < STAGES; s++) begin
        rem_q[s]  <= rem_d[s];
        root_q[s] <= root_d[s];
      end
      for (int s = 1; s < STAGES; s++) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  assign valid_o = v_q[STAGES-1];
  assign root_o  = root_q[STAGES-1][KZ_W-1:0];
  assign side_o  = side_q[STAGES-1];

endmodule

// ===== src/pse_cordic.sv =====
module pse_cordic #(
  parameter int unsigned Stages     = pse_pkg::CORDIC_STAGES_DEF,
  parameter int unsigned SampleBits = pse_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned SideW      = 1
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              en_i,
  input  logic                                              valid_i,
  input  logic signed [SampleBits+pse_pkg::GUARD_BITS+2:0]  x_i,
  input  logic signed [SampleBits+pse_pkg::GUARD_BITS+2:0]  y_i,
  input  logic signed [pse_pkg::Z_W-1:0]                    z_i,
  input  logic [SideW-1:0]                                  side_i,
  output logic                                              valid_o,
  output logic signed [SampleBits-1:0]                      re_o,
  output logic signed [SampleBits-1:0]                      im_o,
  output logic [SideW-1:0]                                  side_o
);
  import pse_pkg::*;

  localparam int unsigned DW = SampleBits + GUARD_BITS + 3;
  localparam int unsigned PW = DW + GAIN_W;
  localparam int unsigned NV = Stages + 2;

  localparam logic signed [GAIN_W-1:0] InvGain = GAIN_W'(inv_gain_fx(Stages));
  localparam logic signed [PW-1:0] Rnd   = PW'(1) << (25 + GUARD_BITS);
  localparam logic signed [PW-1:0] SatHi =
    {{(PW-SampleBits+1){1'b0}}, {(SampleBits-1){1'b1}}};
  localparam logic signed [PW-1:0] SatLo =
    {{(PW-SampleBits+1){1'b1}}, {(SampleBits-1){1'b0}}};

  logic [NV-1:0]          v_q;
  logic signed [DW-1:0]   x_q  [Stages];
  logic signed [DW-1:0]   y_q  [Stages];
  logic signed [Z_W-1:0]  z_q  [Stages];
  logic signed [DW-1:0]   x_d  [Stages];
  logic signed [DW-1:0]   y_d  [Stages];
  logic signed [Z_W-1:0]  z_d  [Stages];
  logic [SideW-1:0]       side_q [NV];

  logic signed [PW-1:0]   px_q, py_q;
  logic signed [PW-1:0]   rx, ry;
  logic signed [SampleBits-1:0] re_q, im_q, re_d, im_d;

  for (genvar i = 0; i < Stages; i++) begin : g_iter
    localparam logic signed [Z_W-1:0] Atan = Z_W'(atan_fx(i));
    logic signed [DW-1:0]  xin;
    logic signed [DW-1:0]  yin;
    logic signed [Z_W-1:0] zin;

    if (i == 0) begin : g_first
      assign xin = x_i;
      assign yin = y_i;
      assign zin = z_i;
    end else begin : g_next
      assign xin = x_q[i-1];
      assign yin = y_q[i-1];
      assign zin = z_q[i-1];
    end

    assign x_d[i] = (zin >= 0) ? xin - (yin >>> i) : xin + (yin >>> i);
    assign y_d[i] = (zin >= 0) ? yin + (xin >>> i) : yin - (xin >>> i);
    assign z_d[i] = (zin >= 0) ? zin - Atan : zin + Atan;
  end

  // gain compensation, round half up, saturate
  assign rx = (px_q + Rnd) >>> (26 + GUARD_BITS);
  assign ry = (py_q + Rnd) >>> (26 + GUARD_BITS);

  always_comb begin
    if (rx > SatHi)      re_d = SatHi[SampleBits-1:0];
    else if (rx < SatLo) re_d = SatLo[SampleBits-1:0];
    else                 re_d = rx[SampleBits-1:0];
    if (ry > SatHi)      im_d = SatHi[SampleBits-1:0];
    else if (ry < SatLo) im_d = SatLo[SampleBits-1:0];
    else                 im_d = ry[SampleBits-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NV-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < Stages; i++) begin
        x_q[i] <= x_d[i];
        y_q[i] <= y_d[i];
        z_q[i] <= z_d[i];
      end
      side_q[0] <= side_i;
      for (int i = 1; i < NV; i++) begin
        side_q[i] <= side_q[i-1];
      end
      px_q <= x_q[Stages-1] * InvGain;
      py_q <= y_q[Stages-1] * InvGain;
      re_q <= re_d;
      im_q <= im_d;
    end
  end

  assign valid_o = v_q[NV-1];
  assign re_o    = re_q;
  assign im_o    = im_q;
  assign side_o  = side_q[NV-1];

endmodule

// ===== src/phase_shift_extrapolator_core.sv =====
// Phase-shift extrapolator: rotates one complex spectral sample per item by
// exp(-i * depth * dz * kz), kz = sqrt((omega/v)^2 - kx^2), or zeroes it when
// the wave is evanescent or steeper than the dip limit (was_cut = 1).
// Channels: sample_i (sink) takes sample, omega, kx and depth steps;
// result_o (source) returns one result item per input item, in order.
// Configuration through the APB port: 0x0 inverse velocity, 0x4 depth step,
// 0x8 squared dip cosine. Write only while no items are in flight.
// Throughput: one item per cycle while sample_i.ready is high. The 14-stage
// square root and the 13-stage modulo-2pi reduction take two bits per stage,
// the CORDIC one iteration each.
// Reset clears all valid bits and loads the register defaults; no clearing
// pass. When the receiver stalls, a two-entry output buffer absorbs the
// result in flight; once its second entry fills, the pipeline freezes and
// sample_i.ready drops until the receiver takes a result.
module phase_shift_extrapolator_core #(
  parameter int unsigned CORDIC_STAGES = pse_pkg::CORDIC_STAGES_DEF,
  parameter int unsigned SAMPLE_BITS   = pse_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pse_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  pse_sample_if.sink                      sample_i,
  pse_result_if.source                    result_o
);
  import pse_pkg::*;

  localparam int unsigned SB         = SAMPLE_BITS;
  localparam int unsigned DW         = SB + GUARD_BITS + 3;
  localparam int unsigned ISQ_SIDE_W = 2 * SB + SD_W + 1;
  localparam int unsigned MOD_SIDE_W = 2 * SB + 1;
  localparam int unsigned MOD_STEPS  = PHI_W - THETA_W + 1;
  localparam int unsigned MOD_PER    = 2;
  localparam int unsigned MOD_STAGES = MOD_STEPS / MOD_PER;
  localparam int unsigned OUT_W      = 2 * SB + 1;

  // configuration registers
  logic [INVV_W-1:0] inv_vel_q;
  logic [DZ_W-1:0]   dz_q;
  logic [DIP_W-1:0]  dip_q;
  pse_reg_e          reg_idx;

  assign reg_idx = pse_reg_e'(paddr[CFG_ADDR_W-1:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_vel_q <= INVV_W'(2796203);
      dz_q      <= DZ_W'(2560);
      dip_q     <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_INV_VEL:    inv_vel_q <= pwdata[INVV_W-1:0];
        REG_DEPTH_STEP: dz_q      <= pwdata[DZ_W-1:0];
        REG_DIP_COS:    dip_q     <= pwdata[DIP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_INV_VEL:    prdata = 32'(inv_vel_q);
      REG_DEPTH_STEP: prdata = 32'(dz_q);
      REG_DIP_COS:    prdata = 32'(dip_q);
      default:        prdata = '0;
    endcase
  end

  logic en;
  logic sk_v_q;

  assign en             = !sk_v_q;
  assign sample_i.ready = en;

  // stage 1: omega/v, kx^2, total depth
  logic                   p1_v_q;
  logic [KRAW_W-1:0]      p1_kraw_q;
  logic [KX2_W-1:0]       p1_kx2_q;
  logic [SD_W-1:0]        p1_sd_q;
  logic signed [SB-1:0]   p1_x_q, p1_y_q;
  logic signed [2*KX_W-1:0] kx_sq;

  assign kx_sq = sample_i.wavenumber * sample_i.wavenumber;

  // stage 2: k^2
  logic                   p2_v_q;
  logic [K2_W-1:0]        p2_k2_q;
  logic [KX2_W-1:0]       p2_kx2_q;
  logic [SD_W-1:0]        p2_sd_q;
  logic signed [SB-1:0]   p2_x_q, p2_y_q;
  logic [K_W-1:0]         k_w;

  assign k_w = p1_kraw_q[KRAW_W-1:16];

  // stage 3: q and dip bound
  logic                   p3_v_q;
  logic                   p3_neg_q;
  logic [K2_W-1:0]        p3_q_q;
  logic [RHS_W-1:0]       p3_rhs_q;
  logic [SD_W-1:0]        p3_sd_q;
  logic signed [SB-1:0]   p3_x_q, p3_y_q;

  // stage 4: cut decision
  logic                   p4_v_q;
  logic                   p4_cut_q;
  logic [K2_W-1:0]        p4_q_q;
  logic [SD_W-1:0]        p4_sd_q;
  logic signed [SB-1:0]   p4_x_q, p4_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
      p3_v_q <= 1'b0;
      p4_v_q <= 1'b0;
    end else if (en) begin
      p1_v_q <= sample_i.valid;
      p2_v_q <= p1_v_q;
      p3_v_q <= p2_v_q;
      p4_v_q <= p3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_kraw_q <= sample_i.angular_freq * inv_vel_q;
      p1_kx2_q  <= kx_sq[KX2_W-1:0];
      p1_sd_q   <= sample_i.depth_steps * dz_q;
      p1_x_q    <= sample_i.sample_re;
      p1_y_q    <= sample_i.sample_im;

      p2_k2_q   <= k_w * k_w;
      p2_kx2_q  <= p1_kx2_q;
      p2_sd_q   <= p1_sd_q;
      p2_x_q    <= p1_x_q;
      p2_y_q    <= p1_y_q;

      p3_neg_q  <= p2_k2_q < K2_W'(p2_kx2_q);
      p3_q_q    <= p2_k2_q - K2_W'(p2_kx2_q);
      p3_rhs_q  <= p2_k2_q * dip_q;
      p3_sd_q   <= p2_sd_q;
      p3_x_q    <= p2_x_q;
      p3_y_q    <= p2_y_q;

      // zero q is cut as well, even with a zero bound
      p4_cut_q  <= p3_neg_q || (RHS_W'({p3_q_q, 16'd0}) <= p3_rhs_q);
      p4_q_q    <= p3_q_q;
      p4_sd_q   <= p3_sd_q;
      p4_x_q    <= p3_x_q;
      p4_y_q    <= p3_y_q;
    end
  end

  // kz = floor(sqrt(q))
  logic                  sq_v;
  logic [KZ_W-1:0]       sq_root;
  logic [ISQ_SIDE_W-1:0] sq_side;

  pse_isqrt #(
    .SideW (ISQ_SIDE_W)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (p4_v_q),
    .rad_i   (p4_q_q),
    .side_i  ({p4_cut_q, p4_sd_q, p4_x_q, p4_y_q}),
    .valid_o (sq_v),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // stage 5: phase in 2^-32 rad
  logic                  p5_v_q;
  logic [PHI_W-1:0]      p5_phi_q;
  logic [MOD_SIDE_W-1:0] p5_side_q;
  logic [SD_W-1:0]       sq_sd;

  assign sq_sd = sq_side[2*SB +: SD_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p5_v_q <= 1'b0;
    end else if (en) begin
      p5_v_q <= sq_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p5_phi_q  <= sq_sd * sq_root;
      p5_side_q <= {sq_side[ISQ_SIDE_W-1], sq_side[2*SB-1:0]};
    end
  end

  // phase modulo 2pi: restoring reduction, two multiples per stage
  logic [MOD_STAGES-1:0] md_v_q;
  logic [PHI_W-1:0]      md_t_q    [MOD_STAGES];
  logic [PHI_W-1:0]      md_t_d    [MOD_STAGES];
  logic [MOD_SIDE_W-1:0] md_side_q [MOD_STAGES];

  for (genvar s = 0; s < MOD_STAGES; s++) begin : g_mod
    logic [PHI_W-1:0] t_in;
    logic [PHI_W-1:0] t_nx;
    logic [PHI_W-1:0] mult;

    if (s == 0) begin : g_first
      assign t_in = p5_phi_q;
    end else begin : g_next
      assign t_in = md_t_q[s-1];
    end

    always_comb begin
      t_nx = t_in;
      mult = '0;
      for (int k = 0; k < MOD_PER; k++) begin
        mult = TWO_PI_PHI << (MOD_STEPS - 1 - (s * MOD_PER + k));
        if (t_nx >= mult) t_nx = t_nx - mult;
      end
    end

    assign md_t_d[s] = t_nx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      md_v_q <= '0;
    end else if (en) begin
      md_v_q <= {md_v_q[MOD_STAGES-2:0], p5_v_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      md_side_q[0] <= p5_side_q;
      for (int s = 0; s < MOD_STAGES; s++) begin
        md_t_q[s] <= md_t_d[s];
      end
      for (int s = 1; s < MOD_STAGES; s++) begin
        md_side_q[s] <= md_side_q[s-1];
      end
    end
  end

  // stage 6: angle -theta into [-pi, pi), then quadrant pre-rotation
  logic signed [Z_W-1:0] theta_s, z_base, z_pre;
  logic signed [DW-1:0]  xg, yg, x_pre, y_pre;
  logic signed [SB-1:0]  md_x, md_y;
  logic                  pr_v_q, pr_cut_q;
  logic signed [Z_W-1:0] pr_z_q;
  logic signed [DW-1:0]  pr_x_q, pr_y_q;

  assign md_x    = md_side_q[MOD_STAGES-1][2*SB-1:SB];
  assign md_y    = md_side_q[MOD_STAGES-1][SB-1:0];
  assign theta_s = Z_W'(md_t_q[MOD_STAGES-1][THETA_W-1:0]);
  assign z_base  = (theta_s > Z_PI) ? Z_TWO_PI - theta_s : -theta_s;
  assign xg      = {{(DW-SB-GUARD_BITS){md_x[SB-1]}}, md_x, {GUARD_BITS{1'b0}}};
  assign yg      = {{(DW-SB-GUARD_BITS){md_y[SB-1]}}, md_y, {GUARD_BITS{1'b0}}};

  always_comb begin
    x_pre = xg;
    y_pre = yg;
    z_pre = z_base;
    if (z_base > Z_HALF_PI) begin
      x_pre = -yg;
      y_pre = xg;
      z_pre = z_base - Z_HALF_PI;
    end else if (z_base < -Z_HALF_PI) begin
      x_pre = yg;
      y_pre = -xg;
      z_pre = z_base + Z_HALF_PI;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pr_v_q <= 1'b0;
    end else if (en) begin
      pr_v_q <= md_v_q[MOD_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pr_cut_q <= md_side_q[MOD_STAGES-1][MOD_SIDE_W-1];
      pr_z_q   <= z_pre;
      pr_x_q   <= x_pre;
      pr_y_q   <= y_pre;
    end
  end

  logic                 cr_v;
  logic signed [SB-1:0] cr_re, cr_im;
  logic                 cr_cut;

  pse_cordic #(
    .Stages     (CORDIC_STAGES),
    .SampleBits (SB),
    .SideW      (1)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pr_v_q),
    .x_i     (pr_x_q),
    .y_i     (pr_y_q),
    .z_i     (pr_z_q),
    .side_i  (pr_cut_q),
    .valid_o (cr_v),
    .re_o    (cr_re),
    .im_o    (cr_im),
    .side_o  (cr_cut)
  );

  // output register plus skid entry
  logic             push, pop;
  logic             out_v_q, out_v_d, sk_v_d;
  logic             out_ld, sk_ld, out_from_sk;
  logic [OUT_W-1:0] new_item, out_data_q, sk_data_q;

  assign push     = en && cr_v;
  assign pop      = out_v_q && result_o.ready;
  assign new_item = cr_cut ? {1'b1, {(2*SB){1'b0}}} : {1'b0, cr_re, cr_im};

  always_comb begin
    out_v_d     = out_v_q;
    sk_v_d      = sk_v_q;
    out_ld      = 1'b0;
    sk_ld       = 1'b0;
    out_from_sk = 1'b0;
    if (push) begin
      if (!out_v_q || pop) begin
        out_v_d = 1'b1;
        out_ld  = 1'b1;
      end else begin
        sk_v_d = 1'b1;
        sk_ld  = 1'b1;
      end
    end else if (pop) begin
      if (sk_v_q) begin
        out_from_sk = 1'b1;
        sk_v_d      = 1'b0;
      end else begin
        out_v_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      sk_v_q  <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
      sk_v_q  <= sk_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) out_data_q <= new_item;
    else if (out_from_sk) out_data_q <= sk_data_q;
    if (sk_ld) sk_data_q <= new_item;
  end

  assign result_o.valid     = out_v_q;
  assign result_o.was_cut   = out_data_q[OUT_W-1];
  assign result_o.result_re = out_data_q[2*SB-1:SB];
  assign result_o.result_im = out_data_q[SB-1:0];

  a_cut_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.was_cut) |->
      (result_o.result_re == '0 && result_o.result_im == '0))
    else $error("cut item carries a nonzero result");

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sk_v_q |-> out_v_q)
    else $error("skid entry held while output register empty");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sk_v_q && result_o.ready) |=> !sk_v_q)
    else $error("skid entry not drained after output taken");

endmodule
